/* rtl/dock_position_pd_controller_macros.svh */
// Assertion macros shared by the dock position PD controller RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef DOCK_POSITION_PD_CONTROLLER_MACROS_SVH
`define DOCK_POSITION_PD_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dpc_pkg.sv */
// Shared types and constants for the dock position PD controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dpc_pkg;

  // Datapath widths.
  localparam int POS_W    = 20;
  localparam int ERR_W    = POS_W + 1;
  localparam int DERR_W   = POS_W + 2;
  localparam int GAIN_W   = 8;
  localparam int PROD_P_W = ERR_W + GAIN_W + 1;
  localparam int PROD_D_W = DERR_W + GAIN_W + 1;
  localparam int SUM_W    = PROD_D_W + 1;
  localparam int QFRAC    = 4;
  localparam int QUOT_W   = SUM_W - QFRAC;
  localparam int DRV_W    = 8;
  localparam int CEIL_W   = 7;
  localparam int REQ_W    = 2;

  // Register port geometry.
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = ADDR_W - 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SETPOINT_DOWN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SETPOINT_UP   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd5;

  // Requested state codes.
  localparam logic [REQ_W-1:0] REQ_UP   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DOWN = 2'd1;

  // Register reset values.
  localparam logic [GAIN_W-1:0]        GAIN_PROP_RST  = 8'd24;
  localparam logic [GAIN_W-1:0]        GAIN_DERIV_RST = 8'd8;
  localparam logic signed [POS_W-1:0]  SP_DOWN_RST    = POS_W'(-510);
  localparam logic signed [POS_W-1:0]  SP_UP_RST      = POS_W'(-410);
  localparam logic signed [DRV_W-1:0]  FLOOR_RST      = DRV_W'(-127);
  localparam logic [CEIL_W-1:0]        CEIL_RST       = 7'd127;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain_prop;
    logic [GAIN_W-1:0]       gain_deriv;
    logic signed [POS_W-1:0] setpoint_down;
    logic signed [POS_W-1:0] setpoint_up;
    logic signed [DRV_W-1:0] drive_floor;
    logic [CEIL_W-1:0]       drive_ceiling;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    manual_hold;
    logic [REQ_W-1:0]        requested_state;
  } item_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic                    drive_valid;
    logic                    reported_state;
  } result_t;

endpackage

/* rtl/dpc_cfg_regs.sv */
// APB-style configuration register file for the dock position PD controller.
// Depends on dpc_pkg for register indexes, reset values and the cfg_t struct.
`timescale 1ns / 1ps

module dpc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpc_pkg::DATA_W-1:0]  pwdata,
  output logic [dpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output dpc_pkg::cfg_t               cfg
);
  import dpc_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop     <= GAIN_PROP_RST;
      cfg.gain_deriv    <= GAIN_DERIV_RST;
      cfg.setpoint_down <= SP_DOWN_RST;
      cfg.setpoint_up   <= SP_UP_RST;
      cfg.drive_floor   <= FLOOR_RST;
      cfg.drive_ceiling <= CEIL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_PROP:     cfg.gain_prop     <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:    cfg.gain_deriv    <= pwdata[GAIN_W-1:0];
        REG_SETPOINT_DOWN: cfg.setpoint_down <= pwdata[POS_W-1:0];
        REG_SETPOINT_UP:   cfg.setpoint_up   <= pwdata[POS_W-1:0];
        REG_DRIVE_FLOOR:   cfg.drive_floor   <= pwdata[DRV_W-1:0];
        REG_DRIVE_CEILING: cfg.drive_ceiling <= pwdata[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Signed registers read back sign extended.
  always_comb begin
    unique case (idx)
      REG_GAIN_PROP:     prdata = DATA_W'(cfg.gain_prop);
      REG_GAIN_DERIV:    prdata = DATA_W'(cfg.gain_deriv);
      REG_SETPOINT_DOWN: prdata = DATA_W'(cfg.setpoint_down);
      REG_SETPOINT_UP:   prdata = DATA_W'(cfg.setpoint_up);
      REG_DRIVE_FLOOR:   prdata = DATA_W'(cfg.drive_floor);
      REG_DRIVE_CEILING: prdata = DATA_W'(cfg.drive_ceiling);
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/dpc_core.sv */
// Controller state and PD control law for the dock position PD controller.
// Depends on dpc_pkg for widths, state codes and the cfg_t, item_t, result_t structs.
`timescale 1ns / 1ps

module dpc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  dpc_pkg::item_t   item,
  input  dpc_pkg::cfg_t    cfg,
  output dpc_pkg::result_t result
);
  import dpc_pkg::*;

  logic signed [POS_W-1:0]    target_position;
  logic signed [POS_W-1:0]    target_position_next;
  logic signed [ERR_W-1:0]    previous_error;
  logic signed [ERR_W-1:0]    previous_error_next;
  logic                       last_state;
  logic                       last_state_next;
  logic                       target_captured;
  logic                       target_captured_next;

  logic signed [POS_W-1:0]    tgt;
  logic                       st;
  logic signed [ERR_W-1:0]    err;
  logic signed [DERR_W-1:0]   derr;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_adj;
  logic signed [QUOT_W-1:0]   quot;
  logic signed [QUOT_W-1:0]   floor_ext;
  logic signed [QUOT_W-1:0]   ceil_ext;
  logic signed [QUOT_W-1:0]   lo_clamped;
  logic signed [QUOT_W-1:0]   hi_clamped;

  // Setpoint selection. Only a change of request moves the target; a code
  // other than up or down keeps the target and is recorded as up.
  always_comb begin
    tgt = target_position;
    st  = item.requested_state[0];
    if (item.requested_state != {1'b0, last_state}) begin
      if (item.requested_state == REQ_DOWN) begin
        tgt = cfg.setpoint_down;
      end else if (item.requested_state == REQ_UP) begin
        tgt = cfg.setpoint_up;
      end else begin
        st = 1'b0;
      end
    end
  end

  // PD law in Q4.4, then truncation toward zero and the two clamps.
  always_comb begin
    err        = ERR_W'(tgt) - ERR_W'(item.position);
    derr       = DERR_W'(err) - DERR_W'(previous_error);
    prod_p     = PROD_P_W'($signed({1'b0, cfg.gain_prop})) * PROD_P_W'(err);
    prod_d     = PROD_D_W'($signed({1'b0, cfg.gain_deriv})) * PROD_D_W'(derr);
    sum        = SUM_W'(prod_p) + SUM_W'(prod_d);
    sum_adj    = sum + (sum[SUM_W-1] ? SUM_W'((1 << QFRAC) - 1) : SUM_W'(0));
    quot       = QUOT_W'(sum_adj >>> QFRAC);
    floor_ext  = QUOT_W'(cfg.drive_floor);
    ceil_ext   = QUOT_W'($signed({1'b0, cfg.drive_ceiling}));
    lo_clamped = (quot < floor_ext) ? floor_ext : quot;
    hi_clamped = (lo_clamped > ceil_ext) ? ceil_ext : lo_clamped;
  end

  always_comb begin
    target_position_next = target_position;
    previous_error_next  = previous_error;
    last_state_next      = last_state;
    target_captured_next = target_captured;
    result.drive          = '0;
    result.drive_valid    = 1'b0;
    result.reported_state = last_state;
    if (item.manual_hold) begin
      target_captured_next = 1'b0;
    end else if (!target_captured) begin
      target_position_next = item.position;
      target_captured_next = 1'b1;
    end else begin
      target_position_next  = tgt;
      last_state_next       = st;
      previous_error_next   = err;
      result.drive          = DRV_W'(hi_clamped);
      result.drive_valid    = 1'b1;
      result.reported_state = st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      previous_error  <= '0;
      last_state      <= 1'b0;
      target_captured <= 1'b0;
    end else if (advance) begin
      target_position <= target_position_next;
      previous_error  <= previous_error_next;
      last_state      <= last_state_next;
      target_captured <= target_captured_next;
    end
  end

endmodule

/* rtl/dock_position_pd_controller.sv */
// Flow: an item accepted at a clock edge goes into the input register and moves on into the
// result register once that register is free; a stall on the result side holds it there.
// Throughput: one item per cycle while the result side does not stall; the controller state
// loop runs from the state registers through the PD law back to the state registers.
// Reset (synchronous, active high) empties both stages, clears the controller state and
// loads the configuration registers with their default values.
`timescale 1ns / 1ps
`include "dock_position_pd_controller_macros.svh"

// Top level of the dock position PD controller: input register, core and result
// register, plus the configuration port. Depends on dpc_pkg, dpc_cfg_regs and dpc_core.
module dock_position_pd_controller (
  input  logic                               clk,
  input  logic                               rst,
  // Input item channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [dpc_pkg::POS_W-1:0]   position,
  input  logic                               manual_hold,
  input  logic [dpc_pkg::REQ_W-1:0]          requested_state,
  // Result item channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dpc_pkg::DRV_W-1:0]   drive,
  output logic                               drive_valid,
  output logic                               reported_state,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dpc_pkg::ADDR_W-1:0]         paddr,
  input  logic [dpc_pkg::DATA_W-1:0]         pwdata,
  output logic [dpc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import dpc_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t core_result;
  result_t out_result;

  // The input register feeds the core. Its item moves into the result register,
  // and the controller state commits, whenever the result register is empty or is
  // being emptied in the same cycle. The input register refills in that same cycle, but
  // while a stalled result holds the item in the input register, no new item is accepted.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.position        <= position;
      s1_item.manual_hold     <= manual_hold;
      s1_item.requested_state <= requested_state;
    end
  end

  dpc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Result register: it loads on every advance and otherwise holds, and its valid
  // flag drops once the waiting item has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign drive          = out_result.drive;
  assign drive_valid    = out_result.drive_valid;
  assign reported_state = out_result.reported_state;

  // Terms used by the checks below.
  logic                    hold_advance;
  logic                    undriven_out;
  logic signed [DRV_W-1:0] ceil_val;
  logic                    driven_ordered;
  logic                    drive_in_range;

  assign hold_advance   = advance && s1_item.manual_hold;
  assign undriven_out   = out_valid && !drive_valid;
  assign ceil_val       = $signed({1'b0, cfg.drive_ceiling});
  assign driven_ordered = out_valid && drive_valid && (cfg.drive_floor <= ceil_val);
  assign drive_in_range = (drive >= cfg.drive_floor) && (drive <= ceil_val);

  // An item taken under manual hold must come out as a result with no drive.
  `DPC_ASSERT_NEXT(a_hold_no_drive, hold_advance, undriven_out, "held item produced a drive")
  // A result with no drive carries a zero drive value.
  `DPC_ASSERT_NOW(a_idle_drive_zero, undriven_out, drive == '0, "undriven result not zero")
  // With ordered limits every driven result lies between them.
  `DPC_ASSERT_NOW(a_drive_in_limits, driven_ordered, drive_in_range, "drive out of limits")
  // An empty input register always accepts a new item.
  `DPC_ASSERT_NOW(a_empty_accepts, !s1_valid, in_ready, "empty input stage refused an item")

endmodule

/* verif/tb_dock_position_pd_controller.sv */
// Self-checking testbench for the dock position PD controller: directed table, then random
// phases under several register settings. Depends on dpc_pkg and dock_position_pd_controller.
`timescale 1ns / 1ps

module tb_dock_position_pd_controller;
  import dpc_pkg::*;

  // Requested state values that the controller treats as invalid (reported back as up).
  localparam logic [REQ_W-1:0] REQ_RESERVED2 = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESERVED3 = 2'd3;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 155;
  localparam int PHASE_COUNT   = 6;
  localparam int MAX_MISMATCH_PRINTS = 40;

  // Extremes of the position field.
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // One row of the directed table. When typed is set, want holds the result written out by
  // hand; otherwise the row is checked against the predictor like any random item.
  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } drill_row_t;

  // Every block input starts at a known value; reset is held from time zero.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [POS_W-1:0]   position = '0;
  logic                      manual_hold = 1'b0;
  logic [REQ_W-1:0]          requested_state = REQ_UP;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DRV_W-1:0]   drive;
  logic                      drive_valid;
  logic                      reported_state;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // Controller state as the predictor sees it, plus its copy of the registers.
  cfg_t                      cfg;
  logic signed [POS_W-1:0]   ctl_target = '0;
  logic signed [ERR_W-1:0]   ctl_prev_err = '0;
  logic [REQ_W-1:0]          ctl_last = REQ_UP;
  bit                        ctl_captured = 1'b0;

  // Drive results still to come out of the block, oldest first.
  result_t                   awaited[$];
  drill_row_t                drill_rows[$];

  int  cycles = 0;
  int  mismatches = 0;
  int  n_items = 0;
  int  n_checked = 0;
  int  n_holds = 0;
  int  n_captures = 0;
  int  n_settings = 0;
  bit  no_idle = 1'b0;
  int  stall_left = 0;

  dock_position_pd_controller dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .position        (position),
    .manual_hold     (manual_hold),
    .requested_state (requested_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .drive           (drive),
    .drive_valid     (drive_valid),
    .reported_state  (reported_state),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: simulation ran past %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Advances the controller by one accepted item and returns the result it should produce.
  // Hold and capture ticks report the last state with no drive, and neither of them touches
  // the derivative history. A changed request of 1 or 0 loads the matching setpoint; any
  // other value keeps the target and is recorded and reported as up.
  function automatic result_t step_controller(item_t it);
    result_t                 r;
    logic [REQ_W-1:0]        req;
    logic signed [ERR_W-1:0] err;
    logic signed [DERR_W-1:0] derr;
    longint                  gp, gd, e, de, q, lo, hi;
    r = '0;
    r.reported_state = ctl_last[0];
    if (it.manual_hold) begin
      ctl_captured = 1'b0;
      n_holds++;
      return r;
    end
    if (!ctl_captured) begin
      ctl_target = it.position;
      ctl_captured = 1'b1;
      n_captures++;
      return r;
    end
    req = it.requested_state;
    if (req != ctl_last) begin
      if (req == REQ_DOWN) begin
        ctl_target = cfg.setpoint_down;
      end else if (req == REQ_UP) begin
        ctl_target = cfg.setpoint_up;
      end else begin
        req = REQ_UP;
      end
    end
    ctl_last = req;
    err = ERR_W'(ctl_target) - ERR_W'(it.position);
    derr = DERR_W'(err) - DERR_W'(ctl_prev_err);
    ctl_prev_err = err;
    // Exact Q4.4 sum, then one division that truncates toward zero.
    gp = longint'(cfg.gain_prop);
    gd = longint'(cfg.gain_deriv);
    e = longint'(err);
    de = longint'(derr);
    q = (gp * e + gd * de) / (64'sd1 <<< QFRAC);
    // Floor first, ceiling second: the ceiling wins if the limits ever cross.
    lo = longint'(cfg.drive_floor);
    hi = longint'(cfg.drive_ceiling);
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    r.drive = DRV_W'(q);
    r.drive_valid = 1'b1;
    r.reported_state = ctl_last[0];
    return r;
  endfunction

  function automatic cfg_t make_cfg(int gp, int gd, int sd, int su, int fl, int ce);
    cfg_t c;
    c.gain_prop = GAIN_W'(gp);
    c.gain_deriv = GAIN_W'(gd);
    c.setpoint_down = POS_W'(sd);
    c.setpoint_up = POS_W'(su);
    c.drive_floor = DRV_W'(fl);
    c.drive_ceiling = CEIL_W'(ce);
    return c;
  endfunction

  function automatic void add_row(int pos, bit hold, logic [REQ_W-1:0] req,
                                  bit typed, int drv, bit dv, bit st);
    drill_row_t row;
    row.it.position = POS_W'(pos);
    row.it.manual_hold = hold;
    row.it.requested_state = req;
    row.typed = typed;
    row.want.drive = DRV_W'(drv);
    row.want.drive_valid = dv;
    row.want.reported_state = st;
    drill_rows.push_back(row);
  endfunction

  // Random tick. Most ticks stay close to the active target so that the drive is not
  // always pinned at a limit; the rest are wide positions, extremes, holds, and
  // requests that flip or are invalid.
  function automatic item_t random_item();
    item_t                   it;
    int                      pick;
    int                      offs;
    logic signed [POS_W-1:0] base;
    it.manual_hold = ($urandom_range(0, 99) < 4);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      it.requested_state = ctl_last;
    end else if (pick < 85) begin
      it.requested_state = (ctl_last == REQ_UP) ? REQ_DOWN : REQ_UP;
    end else if (pick < 95) begin
      it.requested_state = $urandom_range(0, 1) ? REQ_RESERVED2 : REQ_RESERVED3;
    end else begin
      it.requested_state = REQ_W'($urandom);
    end
    if (it.requested_state != ctl_last && it.requested_state == REQ_DOWN) begin
      base = cfg.setpoint_down;
    end else if (it.requested_state != ctl_last && it.requested_state == REQ_UP) begin
      base = cfg.setpoint_up;
    end else begin
      base = ctl_target;
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      offs = int'($urandom_range(0, 128)) - 64;
      it.position = POS_W'(int'(base) + offs);
    end else if (pick < 75) begin
      offs = int'($urandom_range(0, 4096)) - 2048;
      it.position = POS_W'(int'(base) + offs);
    end else if (pick < 92) begin
      it.position = POS_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       it.position = POS_MAX;
        1:       it.position = POS_MIN;
        2:       it.position = '0;
        default: it.position = '1;
      endcase
    end
    return it;
  endfunction

  // Sender idle gap before an item. Every third block of 32 items runs without gaps.
  function automatic int pick_gap(int k);
    if (no_idle || (k % 96) < 32) return 0;
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, 8);
    return 0;
  endfunction

  // Offers one item and waits for it to be accepted; the prediction is made right at
  // the accepting edge so that it sees the state left by every earlier item. A gap
  // lowers valid first, so valid is never lowered and raised in one time step.
  task automatic feed(item_t it, bit typed, result_t typed_res, int gap);
    result_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    position <= it.position;
    manual_hold <= it.manual_hold;
    requested_state <= it.requested_state;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = step_controller(it);
    awaited.push_back(typed ? typed_res : r);
    n_items++;
  endtask

  // Stops offering items and waits until every expected result has come out. It always
  // lets at least one edge pass, so the caller never drives valid twice in one step.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  // Register write: setup cycle, then access cycle; the register takes the data at the
  // edge where the access phase meets pready. An idle bus phase follows each write.
  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN_PROP:     cfg.gain_prop = val[GAIN_W-1:0];
      REG_GAIN_DERIV:    cfg.gain_deriv = val[GAIN_W-1:0];
      REG_SETPOINT_DOWN: cfg.setpoint_down = val[POS_W-1:0];
      REG_SETPOINT_UP:   cfg.setpoint_up = val[POS_W-1:0];
      REG_DRIVE_FLOOR:   cfg.drive_floor = val[DRV_W-1:0];
      REG_DRIVE_CEILING: cfg.drive_ceiling = val[CEIL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Signed registers are written sign extended to the full data width.
  task automatic load_config(cfg_t c);
    reg_write(REG_GAIN_PROP, DATA_W'(c.gain_prop));
    reg_write(REG_GAIN_DERIV, DATA_W'(c.gain_deriv));
    reg_write(REG_SETPOINT_DOWN, DATA_W'($signed(c.setpoint_down)));
    reg_write(REG_SETPOINT_UP, DATA_W'($signed(c.setpoint_up)));
    reg_write(REG_DRIVE_FLOOR, DATA_W'($signed(c.drive_floor)));
    reg_write(REG_DRIVE_CEILING, DATA_W'(c.drive_ceiling));
    n_settings++;
  endtask

  // Result side back-pressure: random stalls of random length, a calm window while bit 8 of
  // the cycle counter is set, and none at all once the final phase starts.
  always @(posedge clk) begin
    if (rst || no_idle || cycles[8]) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: each accepted result against the oldest expectation, field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_PRINTS)
          $display("%0t: result with no item pending: drive %0d valid %0b state %0b",
                   $time, drive, drive_valid, reported_state);
      end else begin
        want = awaited.pop_front();
        n_checked++;
        if (drive !== want.drive || drive_valid !== want.drive_valid ||
            reported_state !== want.reported_state) begin
          mismatches++;
          if (mismatches <= MAX_MISMATCH_PRINTS) begin
            if (drive !== want.drive)
              $display("%0t: drive expected %0d, got %0d", $time, want.drive, drive);
            if (drive_valid !== want.drive_valid)
              $display("%0t: drive_valid expected %0b, got %0b",
                       $time, want.drive_valid, drive_valid);
            if (reported_state !== want.reported_state)
              $display("%0t: reported_state expected %0b, got %0b",
                       $time, want.reported_state, reported_state);
          end
        end
      end
    end
  end

  initial begin
    cfg_t    plan [PHASE_COUNT];
    result_t none;
    none = '0;
    cfg = make_cfg(GAIN_PROP_RST, GAIN_DERIV_RST, $signed(SP_DOWN_RST), $signed(SP_UP_RST),
                   $signed(FLOOR_RST), CEIL_RST);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset register values (gains 1.5 and 0.5, setpoints -510
    // and -410, limits -127 and 127). Columns: position, hold, request, typed, then the
    // hand-worked drive, drive_valid and reported state.
    add_row(0, 0, REQ_UP, 1, 0, 0, 0);              // first tick after reset captures
    add_row(POS_MAX, 1, REQ_RESERVED3, 1, 0, 0, 0); // manual hold drops the capture
    add_row(100, 0, REQ_UP, 1, 0, 0, 0);            // capture again at 100
    add_row(100, 0, REQ_UP, 1, 0, 1, 0);            // unchanged request, zero error
    add_row(0, 0, REQ_DOWN, 1, -127, 1, 1);         // down setpoint, floor clamp
    add_row(-510, 0, REQ_DOWN, 1, 127, 1, 1);       // derivative alone hits the ceiling
    add_row(-410, 0, REQ_RESERVED2, 1, -127, 1, 0); // invalid request keeps the target
    add_row(-510, 0, REQ_UP, 1, 50, 1, 0);          // target is still the down setpoint
    add_row(-510, 0, REQ_RESERVED3, 1, 0, 1, 0);    // invalid while already up
    add_row(POS_MAX, 0, REQ_UP, 1, -127, 1, 0);     // largest negative error
    add_row(POS_MIN, 0, REQ_UP, 1, 127, 1, 0);      // largest positive error step
    add_row(POS_MIN, 0, REQ_DOWN, 1, 127, 1, 1);
    add_row(POS_MAX, 0, REQ_UP, 1, -127, 1, 0);
    add_row(5, 1, REQ_DOWN, 1, 0, 0, 0);            // hold keeps the last state
    add_row(-400, 0, REQ_DOWN, 1, 0, 0, 0);         // capture ignores the request
    add_row(-400, 0, REQ_UP, 1, 127, 1, 0);         // error history survived the hold
    add_row(-401, 0, REQ_UP, 1, 2, 1, 0);
    add_row(-400, 0, REQ_UP, 1, 0, 1, 0);           // -8/16 truncates to zero
    add_row(-399, 0, REQ_UP, 0, 0, 0, 0);
    add_row(12345, 0, REQ_DOWN, 0, 0, 0, 0);
    add_row(-77, 0, REQ_RESERVED2, 0, 0, 0, 0);
    add_row(0, 1, REQ_UP, 0, 0, 0, 0);
    add_row(-1, 0, REQ_DOWN, 0, 0, 0, 0);
    add_row(-1, 0, REQ_DOWN, 0, 0, 0, 0);
    foreach (drill_rows[i])
      feed(drill_rows[i].it, drill_rows[i].typed, drill_rows[i].want, pick_gap(i));

    // Register settings for the random phases: the extremes of every register, a
    // fine-grained setting where truncation matters, two random ones, and a moderate one
    // for the final phase, which runs with no idling on either side.
    plan[0] = make_cfg(255, 255, int'(POS_MIN), int'(POS_MAX), -128, 0);
    plan[1] = make_cfg(0, 0, 0, 0, 0, 127);
    plan[2] = make_cfg(1, 0, 10, -10, -1, 1);
    plan[3] = make_cfg($urandom_range(0, 255), $urandom_range(0, 255), int'($urandom),
                       int'($urandom), -int'($urandom_range(0, 128)), $urandom_range(0, 127));
    plan[4] = make_cfg($urandom_range(0, 255), $urandom_range(0, 255), int'($urandom),
                       int'($urandom), -int'($urandom_range(0, 128)), $urandom_range(0, 127));
    plan[5] = make_cfg(16, 24, -500, 500, -128, 127);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // Registers change only once the block has handed back every result.
      wait_results_done();
      if (p == PHASE_COUNT - 1) no_idle = 1'b1;
      load_config(plan[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Once, midway through the first phase, hold the sender back until the block has fully drained.
        if (p == 0 && k == 60) wait_results_done();
        feed(random_item(), 1'b0, none, pick_gap(k));
      end
    end

    wait_results_done();
    repeat (8) @(posedge clk);

    $display("Sent %0d items under %0d register settings besides the defaults.",
             n_items, n_settings);
    $display("Checked %0d results, including %0d hold ticks and %0d target captures.",
             n_checked, n_holds, n_captures);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dpc_pkg.sv
rtl/dpc_cfg_regs.sv
rtl/dpc_core.sv
rtl/dock_position_pd_controller.sv
verif/tb_dock_position_pd_controller.sv
